// File: design/lcadc_pkg.sv
`default_nettype none

package lcadc_pkg;

    localparam int SHIFT_W   = 24;
    localparam int SUM_W     = 32;
    localparam int UNITS_W   = 48;
    localparam int DIFF_W    = 25;
    localparam int DIVISOR_W = 32;
    localparam int NARROW_W  = 32;
    localparam int DIV_W     = DIFF_W + DIVISOR_W;
    localparam int CNT_W     = 6;

    localparam logic [1:0] KIND_MEASURE = 2'd1;
    localparam logic [1:0] KIND_TARE    = 2'd2;

    localparam logic [1:0] GAIN_128 = 2'd0;
    localparam logic [1:0] GAIN_64  = 2'd1;

    localparam logic [1:0] REG_GAIN  = 2'd0;
    localparam logic [1:0] REG_COUNT = 2'd1;
    localparam logic [1:0] REG_SCALE = 2'd2;

    localparam logic [31:0] SCALE_RESET = 32'h0001_0000;
    localparam logic [31:0] SCALE_ZERO  = 32'h0000_0000;

    localparam logic [UNITS_W-1:0] UNITS_MAX = {1'b0, {(UNITS_W-1){1'b1}}};
    localparam logic [UNITS_W-1:0] UNITS_MIN = {1'b1, {(UNITS_W-1){1'b0}}};

    typedef enum logic [5:0] {
        PH_IDLE     = 6'b000001,
        PH_WAIT     = 6'b000010,
        PH_BIT_HI   = 6'b000100,
        PH_BIT_LO   = 6'b001000,
        PH_PULSE_HI = 6'b010000,
        PH_PULSE_LO = 6'b100000
    } phase_t;

    typedef enum logic [3:0] {
        SQ_READY = 4'b0001,
        SQ_AVG   = 4'b0010,
        SQ_SETUP = 4'b0100,
        SQ_UNITS = 4'b1000
    } seq_t;

    typedef struct packed {
        logic start;
        logic narrow;
    } div_ctl_t;

    typedef struct packed {
        logic busy;
        logic done;
    } div_stat_t;

    function automatic logic [1:0] pulses_needed(input logic [1:0] gain);
        logic [1:0] n;
        unique case (gain)
            GAIN_128: n = 2'd1;
            GAIN_64:  n = 2'd3;
            default:  n = 2'd2;
        endcase
        return n;
    endfunction

endpackage

`default_nettype wire

// File: design/lcadc_div.sv
`default_nettype none

// radix-2 restoring divider, unsigned; narrow requests use the low 32 dividend bits
module lcadc_div
    import lcadc_pkg::*;
(
    input  wire logic                 clk,
    input  wire logic                 rst_n,
    input  wire div_ctl_t             ctl,
    input  wire logic [DIV_W-1:0]     dividend,
    input  wire logic [DIVISOR_W-1:0] divisor,
    output div_stat_t                 stat,
    output logic [DIV_W-1:0]          quotient
);

    logic [DIVISOR_W:0]   rem_reg;
    logic [DIV_W-1:0]     quo_reg;
    logic [DIVISOR_W-1:0] dvs_reg;
    logic [CNT_W-1:0]     cnt_reg;
    logic                 run_reg;
    logic                 done_reg;

    logic [DIVISOR_W:0]   rem_shift;
    logic [DIVISOR_W+1:0] trial;
    logic                 fits;

    always_comb
    begin
        rem_shift = {rem_reg[DIVISOR_W-1:0], quo_reg[DIV_W-1]};
        trial     = {1'b0, rem_shift} - {2'b00, dvs_reg};
        fits      = ~trial[DIVISOR_W+1];
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            run_reg  <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
        end
        else if (ctl.start)
        begin
            run_reg  <= 1'b1;
            done_reg <= 1'b0;
            cnt_reg  <= ctl.narrow ? CNT_W'(NARROW_W) : CNT_W'(DIV_W);
        end
        else if (run_reg)
        begin
            cnt_reg <= cnt_reg - CNT_W'(1);
            if (cnt_reg == CNT_W'(1))
            begin
                run_reg  <= 1'b0;
                done_reg <= 1'b1;
            end
        end
        else
        begin
            done_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (ctl.start)
        begin
            rem_reg <= '0;
            dvs_reg <= divisor;
            quo_reg <= ctl.narrow ? {dividend[NARROW_W-1:0], {(DIV_W-NARROW_W){1'b0}}}
                                  : dividend;
        end
        else if (run_reg)
        begin
            rem_reg <= fits ? trial[DIVISOR_W:0] : rem_shift;
            quo_reg <= {quo_reg[DIV_W-2:0], fits};
        end
    end

    assign stat.busy = run_reg;
    assign stat.done = done_reg;
    assign quotient  = quo_reg;

endmodule

`default_nettype wire

// File: design/load_cell_adc_serial_reader_unit.sv
`default_nettype none

// channel | dir | handshake           | payload
// in      | in  | in_valid/in_stall   | kind, dout_level
// out     | out | out_valid/out_stall | sck_level, busy_res, result_valid, result_is_tare,
//         |     |                     | raw_average, units_q16, scale_error
// cfg     | in  | cfg_valid/cfg_ready | cfg_index, cfg_data
//
// Ordinary ticks: result registered at the accepting edge, one request per cycle when input is not stalled.
// Last tick of a tare or zero-scale measurement: a 32-step divider pass.
// Last tick of a measurement: the 32-step average pass plus a 57-step pass.
// Input is stalled while the divider sequence runs or a result waits on out_stall.
// Reset clears configuration to gain 128, count 1, scale 1.0 and the reader to idle.
module load_cell_adc_serial_reader_unit
    import lcadc_pkg::*;
#(
    parameter int SAMPLE_BITS = 24
)
(
    input  wire logic               clk,
    input  wire logic               rst_n,

    input  wire logic               in_valid,
    output logic                    in_stall,
    input  wire logic [1:0]         kind,
    input  wire logic               dout_level,

    output logic                    out_valid,
    input  wire logic               out_stall,
    output logic                    sck_level,
    output logic                    busy_res,
    output logic                    result_valid,
    output logic                    result_is_tare,
    output logic signed [23:0]      raw_average,
    output logic signed [47:0]      units_q16,
    output logic                    scale_error,

    input  wire logic               cfg_valid,
    output logic                    cfg_ready,
    input  wire logic [1:0]         cfg_index,
    input  wire logic [31:0]        cfg_data
);

    localparam logic [4:0] BITS_LIMIT = 5'(SAMPLE_BITS);

    logic [1:0]          gain_reg;
    logic [7:0]          count_reg;
    logic [31:0]         scale_reg;

    phase_t              phase_reg, phase_next;
    logic [4:0]          bit_cnt_reg, bit_cnt_next;
    logic [1:0]          pulse_cnt_reg, pulse_cnt_next;
    logic [SHIFT_W-1:0]  shift_reg, shift_next;
    logic [SUM_W-1:0]    sum_reg, sum_next;
    logic [7:0]          taken_reg, taken_next;
    logic [SHIFT_W-1:0]  offset_reg;
    logic                tare_reg, tare_next;

    seq_t                seq_reg;
    logic [SHIFT_W-1:0]  avg_reg;
    logic                neg_reg;

    logic                out_valid_reg;
    logic                sck_reg, busy_reg, rv_reg, is_tare_reg, serr_reg;
    logic [SHIFT_W-1:0]  raw_reg;
    logic [UNITS_W-1:0]  units_reg;

    logic                in_acc, out_take;
    logic                step_sck, step_busy, final_tick;
    logic [1:0]          pulse_inc;
    logic [7:0]          taken_inc, cnt_eff;
    logic [SUM_W-1:0]    sample_sext, sum_add, sum_abs;
    logic [SUM_W-1:0]    avg_q, avg_signed;
    logic [DIFF_W-1:0]   diff, diff_abs;
    logic [31:0]         scale_abs;
    logic                units_neg, pos_ovf, neg_ovf;
    logic [UNITS_W-1:0]  units_final;
    logic                finish_short, finish_long;

    div_ctl_t            div_ctl;
    div_stat_t           div_stat;
    logic [DIV_W-1:0]    div_dividend, div_quo;
    logic [DIVISOR_W-1:0] div_divisor;

    assign cfg_ready = 1'b1;
    assign in_acc    = in_valid && !in_stall;
    assign out_take  = out_valid_reg && !out_stall;
    assign in_stall  = (seq_reg != SQ_READY) || (out_valid_reg && out_stall);

    always_comb
    begin
        pulse_inc   = pulse_cnt_reg + 2'd1;
        taken_inc   = taken_reg + 8'd1;
        cnt_eff     = (count_reg == 8'd0) ? 8'd1 : count_reg;
        sample_sext = {{(SUM_W-SAMPLE_BITS){shift_reg[SAMPLE_BITS-1]}},
                       shift_reg[SAMPLE_BITS-1:0]};
        sum_add     = sum_reg + sample_sext;
        sum_abs     = sum_add[SUM_W-1] ? (~sum_add + SUM_W'(1)) : sum_add;
    end

    // one half-phase of the serial reader
    always_comb
    begin
        phase_next     = phase_reg;
        bit_cnt_next   = bit_cnt_reg;
        pulse_cnt_next = pulse_cnt_reg;
        shift_next     = shift_reg;
        sum_next       = sum_reg;
        taken_next     = taken_reg;
        tare_next      = tare_reg;
        step_sck       = 1'b0;
        step_busy      = 1'b1;
        final_tick     = 1'b0;
        unique case (phase_reg)
            PH_IDLE:
            begin
                step_busy = 1'b0;
                if (kind == KIND_MEASURE || kind == KIND_TARE)
                begin
                    tare_next  = (kind == KIND_TARE);
                    sum_next   = '0;
                    taken_next = '0;
                    phase_next = PH_WAIT;
                    step_busy  = 1'b1;
                end
            end
            PH_WAIT:
            begin
                if (!dout_level)
                begin
                    bit_cnt_next   = '0;
                    pulse_cnt_next = '0;
                    shift_next     = '0;
                    phase_next     = PH_BIT_HI;
                end
            end
            PH_BIT_HI:
            begin
                step_sck     = 1'b1;
                shift_next   = {shift_reg[SHIFT_W-2:0], dout_level};
                bit_cnt_next = bit_cnt_reg + 5'd1;
                phase_next   = PH_BIT_LO;
            end
            PH_BIT_LO:
            begin
                phase_next = (bit_cnt_reg >= BITS_LIMIT) ? PH_PULSE_HI : PH_BIT_HI;
            end
            PH_PULSE_HI:
            begin
                step_sck   = 1'b1;
                phase_next = PH_PULSE_LO;
            end
            PH_PULSE_LO:
            begin
                pulse_cnt_next = pulse_inc;
                if (pulse_inc < pulses_needed(gain_reg))
                begin
                    phase_next = PH_PULSE_HI;
                end
                else
                begin
                    sum_next   = sum_add;
                    taken_next = taken_inc;
                    if (taken_inc < cnt_eff)
                    begin
                        phase_next = PH_WAIT;
                    end
                    else
                    begin
                        final_tick = 1'b1;
                        step_busy  = 1'b0;
                        phase_next = PH_IDLE;
                    end
                end
            end
            default:
            begin
                step_busy  = 1'b0;
                phase_next = PH_IDLE;
            end
        endcase
    end

    // average, offset difference and saturation around the divider
    always_comb
    begin
        avg_q      = div_quo[SUM_W-1:0];
        avg_signed = neg_reg ? (~avg_q + SUM_W'(1)) : avg_q;
        diff       = {avg_reg[SHIFT_W-1], avg_reg} - {offset_reg[SHIFT_W-1], offset_reg};
        diff_abs   = diff[DIFF_W-1] ? (~diff + DIFF_W'(1)) : diff;
        scale_abs  = scale_reg[31] ? (~scale_reg + 32'd1) : scale_reg;
        units_neg  = diff[DIFF_W-1] ^ scale_reg[31];
        pos_ovf    = |div_quo[DIV_W-1:UNITS_W-1];
        neg_ovf    = (|div_quo[DIV_W-1:UNITS_W]) ||
                     (div_quo[UNITS_W-1] && (|div_quo[UNITS_W-2:0]));
        if (neg_reg)
            units_final = neg_ovf ? UNITS_MIN : (~div_quo[UNITS_W-1:0] + UNITS_W'(1));
        else
            units_final = pos_ovf ? UNITS_MAX : div_quo[UNITS_W-1:0];

        finish_short = (seq_reg == SQ_SETUP) && (tare_reg || scale_reg == SCALE_ZERO);
        finish_long  = (seq_reg == SQ_UNITS) && div_stat.done;

        div_ctl.narrow = (seq_reg == SQ_READY);
        div_ctl.start  = (in_acc && final_tick) ||
                         ((seq_reg == SQ_SETUP) && !finish_short);
        if (seq_reg == SQ_READY)
        begin
            div_dividend = {{(DIV_W-SUM_W){1'b0}}, sum_abs};
            div_divisor  = {{(DIVISOR_W-8){1'b0}}, cnt_eff};
        end
        else
        begin
            div_dividend = {diff_abs, {DIVISOR_W{1'b0}}};
            div_divisor  = scale_abs;
        end
    end

    lcadc_div u_div (
        .clk      (clk),
        .rst_n    (rst_n),
        .ctl      (div_ctl),
        .dividend (div_dividend),
        .divisor  (div_divisor),
        .stat     (div_stat),
        .quotient (div_quo)
    );

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            gain_reg  <= GAIN_128;
            count_reg <= 8'd1;
            scale_reg <= SCALE_RESET;
        end
        else if (cfg_valid && cfg_ready)
        begin
            unique case (cfg_index)
                REG_GAIN:  gain_reg  <= cfg_data[1:0];
                REG_COUNT: count_reg <= cfg_data[7:0];
                REG_SCALE: scale_reg <= cfg_data;
                default:   ;
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            phase_reg     <= PH_IDLE;
            bit_cnt_reg   <= '0;
            pulse_cnt_reg <= '0;
            shift_reg     <= '0;
            sum_reg       <= '0;
            taken_reg     <= '0;
            tare_reg      <= 1'b0;
            offset_reg    <= '0;
            seq_reg       <= SQ_READY;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            if (in_acc)
            begin
                phase_reg     <= phase_next;
                bit_cnt_reg   <= bit_cnt_next;
                pulse_cnt_reg <= pulse_cnt_next;
                shift_reg     <= shift_next;
                sum_reg       <= sum_next;
                taken_reg     <= taken_next;
                tare_reg      <= tare_next;
            end
            if (finish_short && tare_reg)
                offset_reg <= avg_reg;

            unique case (seq_reg)
                SQ_READY: if (in_acc && final_tick) seq_reg <= SQ_AVG;
                SQ_AVG:   if (div_stat.done) seq_reg <= SQ_SETUP;
                SQ_SETUP: seq_reg <= finish_short ? SQ_READY : SQ_UNITS;
                SQ_UNITS: if (div_stat.done) seq_reg <= SQ_READY;
                default:  seq_reg <= SQ_READY;
            endcase

            if ((in_acc && !final_tick) || finish_short || finish_long)
                out_valid_reg <= 1'b1;
            else if (out_take)
                out_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (in_acc && final_tick)
            neg_reg <= sum_add[SUM_W-1];
        else if (seq_reg == SQ_SETUP)
            neg_reg <= units_neg;

        if (seq_reg == SQ_AVG && div_stat.done)
            avg_reg <= avg_signed[SHIFT_W-1:0];

        priority if (in_acc && !final_tick)
        begin
            sck_reg     <= step_sck;
            busy_reg    <= step_busy;
            rv_reg      <= 1'b0;
            is_tare_reg <= 1'b0;
            raw_reg     <= '0;
            units_reg   <= '0;
            serr_reg    <= 1'b0;
        end
        else if (finish_short)
        begin
            sck_reg     <= 1'b0;
            busy_reg    <= 1'b0;
            rv_reg      <= 1'b1;
            is_tare_reg <= tare_reg;
            raw_reg     <= avg_reg;
            units_reg   <= '0;
            serr_reg    <= !tare_reg;
        end
        else if (finish_long)
        begin
            sck_reg     <= 1'b0;
            busy_reg    <= 1'b0;
            rv_reg      <= 1'b1;
            is_tare_reg <= 1'b0;
            raw_reg     <= avg_reg;
            units_reg   <= units_final;
            serr_reg    <= 1'b0;
        end
        else
        begin
            sck_reg <= sck_reg;
        end
    end

    assign out_valid      = out_valid_reg;
    assign sck_level      = sck_reg;
    assign busy_res       = busy_reg;
    assign result_valid   = rv_reg;
    assign result_is_tare = is_tare_reg;
    assign raw_average    = raw_reg;
    assign units_q16      = units_reg;
    assign scale_error    = serr_reg;

    a_div_in_seq: assert property (@(posedge clk) disable iff (!rst_n)
        (div_stat.busy || div_stat.done) |-> (seq_reg == SQ_AVG || seq_reg == SQ_UNITS))
        else $error("divider active outside its sequence");

    a_seq_phase_idle: assert property (@(posedge clk) disable iff (!rst_n)
        (seq_reg != SQ_READY) |-> (phase_reg == PH_IDLE))
        else $error("reader not idle during result sequence");

    a_result_quiet: assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid && result_valid) |-> (!busy_res && !sck_level))
        else $error("result with busy or serial clock high");

    a_scale_err: assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid && scale_error) |-> (result_valid && !result_is_tare && units_q16 == '0))
        else $error("scale error on wrong result");

endmodule

`default_nettype wire

// File: verif/load_cell_adc_serial_reader_unit_test.sv
`timescale 1ns / 1ps

module load_cell_adc_serial_reader_unit_test;
    import lcadc_pkg::*;

    localparam logic [1:0] KIND_TICK  = 2'd0;
    localparam logic [1:0] KIND_SPARE = 2'd3;
    localparam logic [1:0] GAIN_32    = 2'd2;
    localparam logic [1:0] GAIN_SPARE = 2'd3;

    localparam int RANDOM_TICKS   = 150;
    localparam int RANDOM_AVERAGES = 1;
    localparam int HOLD_CYCLES    = 300;
    localparam int STALL_LIMIT    = 4000;

    typedef enum logic [2:0] {
        RD_IDLE,
        RD_WAIT,
        RD_BIT_HI,
        RD_BIT_LO,
        RD_PULSE_HI,
        RD_PULSE_LO
    } rd_phase_t;

    typedef struct packed {
        logic        sck;
        logic        busy;
        logic        valid;
        logic        is_tare;
        logic [23:0] avg;
        logic [47:0] units;
        logic        serr;
    } reading_t;

    logic        clk = 1'b0;
    logic        rst_n = 1'b0;
    logic        in_valid = 1'b0;
    logic        in_stall;
    logic [1:0]  kind = KIND_TICK;
    logic        dout_level = 1'b1;
    logic        out_valid;
    logic        out_stall = 1'b0;
    logic        sck_level;
    logic        busy_res;
    logic        result_valid;
    logic        result_is_tare;
    logic signed [23:0] raw_average;
    logic signed [47:0] units_q16;
    logic        scale_error;
    logic        cfg_valid = 1'b0;
    logic        cfg_ready;
    logic [1:0]  cfg_index = REG_GAIN;
    logic [31:0] cfg_data = 32'd0;

    // reader state as predicted
    rd_phase_t   rd_phase = RD_IDLE;
    logic [4:0]  rd_bits = '0;
    logic [1:0]  rd_pulses = '0;
    logic [23:0] rd_shift = '0;
    logic [31:0] rd_sum = '0;
    logic [7:0]  rd_taken = '0;
    logic [23:0] rd_offset = '0;
    logic        rd_tare = 1'b0;
    logic        rd_conv_done = 1'b0;

    logic [1:0]  cf_gain = GAIN_128;
    logic [7:0]  cf_count = 8'd1;
    logic [31:0] cf_scale = SCALE_RESET;

    reading_t    readings_due[$];
    int          ticks_sent = 0;
    int          averages_done = 0;
    int          mismatches = 0;
    int          holds_requested = 0;
    int          holds_served = 0;
    bit          tx_idle_on = 1'b1;
    bit          rx_idle_on = 1'b1;

    load_cell_adc_serial_reader_unit i_dut (.*);

    initial
    begin
        forever #6 clk = ~clk;
    end

    task automatic predict_reading(input logic [1:0] k, input logic d);
        reading_t r;
        int       need;
        int       cnt;
        longint   total;
        longint   avg;
        longint   diff;
        longint   divisor;
        longint   units;
        r = '0;
        r.busy = 1'b1;
        rd_conv_done = 1'b0;
        case (rd_phase)
            RD_IDLE:
            begin
                r.busy = 1'b0;
                if (k == KIND_MEASURE || k == KIND_TARE)
                begin
                    rd_tare = (k == KIND_TARE);
                    rd_sum = '0;
                    rd_taken = '0;
                    rd_phase = RD_WAIT;
                    r.busy = 1'b1;
                end
            end
            RD_WAIT:
            begin
                if (!d)
                begin
                    rd_bits = '0;
                    rd_pulses = '0;
                    rd_shift = '0;
                    rd_phase = RD_BIT_HI;
                end
            end
            RD_BIT_HI:
            begin
                r.sck = 1'b1;
                rd_shift = {rd_shift[22:0], d};
                rd_bits = rd_bits + 1'b1;
                rd_phase = RD_BIT_LO;
            end
            RD_BIT_LO:
                rd_phase = (rd_bits >= SHIFT_W) ? RD_PULSE_HI : RD_BIT_HI;
            RD_PULSE_HI:
            begin
                r.sck = 1'b1;
                rd_phase = RD_PULSE_LO;
            end
            RD_PULSE_LO:
            begin
                rd_pulses = rd_pulses + 1'b1;
                need = (cf_gain == GAIN_128) ? 1 : (cf_gain == GAIN_64) ? 3 : 2;
                if (rd_pulses < need)
                    rd_phase = RD_PULSE_HI;
                else
                begin
                    rd_conv_done = 1'b1;
                    rd_sum = rd_sum + {{8{rd_shift[23]}}, rd_shift};
                    rd_taken = rd_taken + 1'b1;
                    cnt = (cf_count == 8'd0) ? 1 : int'(cf_count);
                    if (rd_taken < cnt)
                        rd_phase = RD_WAIT;
                    else
                    begin
                        total = longint'($signed(rd_sum));
                        avg = total / cnt;
                        r.avg = avg[23:0];
                        r.valid = 1'b1;
                        r.busy = 1'b0;
                        rd_phase = RD_IDLE;
                        averages_done++;
                        if (rd_tare)
                        begin
                            r.is_tare = 1'b1;
                            rd_offset = avg[23:0];
                        end
                        else
                        begin
                            divisor = longint'($signed(cf_scale));
                            diff = longint'($signed(r.avg)) - longint'($signed(rd_offset));
                            if (divisor == 0)
                                r.serr = 1'b1;
                            else
                            begin
                                units = (diff * 64'sh1_0000_0000) / divisor;
                                if (units > longint'($signed(UNITS_MAX)))
                                    units = longint'($signed(UNITS_MAX));
                                if (units < longint'($signed(UNITS_MIN)))
                                    units = longint'($signed(UNITS_MIN));
                                r.units = units[47:0];
                            end
                        end
                    end
                end
            end
            default:
                rd_phase = RD_IDLE;
        endcase
        readings_due.push_back(r);
    endtask

    task automatic send_tick(input logic [1:0] k, input logic d);
        int gap;
        gap = tx_idle_on ? int'($urandom_range(0, 8)) : 0;
        if (gap != 0)
        begin
            in_valid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        in_valid <= 1'b1;
        kind <= k;
        dout_level <= d;
        @(posedge clk);
        while (in_stall) @(posedge clk);
        ticks_sent++;
        predict_reading(k, d);
    endtask

    task automatic tx_quiet();
        in_valid <= 1'b0;
        @(posedge clk);
    endtask

    task automatic wait_drained();
        while (readings_due.size() != 0) @(posedge clk);
    endtask

    task automatic write_reg(input logic [1:0] idx, input logic [31:0] value);
        cfg_valid <= 1'b1;
        cfg_index <= idx;
        cfg_data <= value;
        @(posedge clk);
        while (!cfg_ready) @(posedge clk);
        cfg_valid <= 1'b0;
        case (idx)
            REG_GAIN:  cf_gain = value[1:0];
            REG_COUNT: cf_count = value[7:0];
            REG_SCALE: cf_scale = value;
            default: ;
        endcase
        @(posedge clk);
    endtask

    function automatic logic [23:0] pick_code();
        logic [23:0] c;
        case ($urandom_range(0, 7))
            0: c = 24'h7F_FFFF;
            1: c = 24'h80_0000;
            2: c = 24'h00_0000;
            3: c = 24'hFF_FFFF;
            4: c = 24'($urandom_range(0, 255));
            5: c = 24'd0 - 24'($urandom_range(1, 255));
            default: c = 24'($urandom);
        endcase
        return c;
    endfunction

    function automatic logic [7:0] pick_count();
        logic [7:0] c;
        case ($urandom_range(0, 19))
            0: c = 8'd0;
            1, 2, 3, 4, 5, 6: c = 8'($urandom_range(2, 4));
            default: c = 8'd1;
        endcase
        return c;
    endfunction

    function automatic logic [31:0] pick_scale();
        logic [31:0] s;
        case ($urandom_range(0, 9))
            0: s = SCALE_ZERO;
            1: s = 32'd1;
            2: s = 32'hFFFF_FFFF;
            3: s = 32'h8000_0000;
            4: s = 32'h7FFF_FFFF;
            5: s = SCALE_RESET;
            6: s = $urandom_range(1, 65535);
            7: s = 32'd0 - $urandom_range(1, 65535);
            default: s = $urandom;
        endcase
        return s;
    endfunction

    // drives one conversion from wherever the reader stands; stops once it lands
    task automatic feed_conversion(input logic [23:0] code24, input int not_ready,
                                   input bit noisy);
        int         hold;
        logic [1:0] k;
        logic       d;
        hold = not_ready;
        rd_conv_done = 1'b0;
        while (rd_phase != RD_IDLE && !rd_conv_done)
        begin
            k = noisy ? 2'($urandom_range(0, 3)) : KIND_TICK;
            d = 1'($urandom_range(0, 1));
            if (rd_phase == RD_WAIT)
            begin
                d = (hold != 0);
                if (hold != 0)
                    hold--;
            end
            else if (rd_phase == RD_BIT_HI)
                d = code24[SHIFT_W - 1 - rd_bits];
            send_tick(k, d);
        end
    endtask

    task automatic command_with(input logic [1:0] cmd, input logic [23:0] code24);
        send_tick(cmd, 1'($urandom_range(0, 1)));
        while (rd_phase != RD_IDLE)
            feed_conversion(code24, int'($urandom_range(0, 3)), 1'b0);
    endtask

    task automatic settle_idle();
        while (rd_phase != RD_IDLE)
            feed_conversion(pick_code(), 0, 1'b0);
        tx_quiet();
        wait_drained();
        repeat (4) @(posedge clk);
    endtask

    task automatic set_config(input logic [1:0] gain, input logic [7:0] count,
                              input logic [31:0] scale);
        settle_idle();
        write_reg(REG_GAIN, {30'd0, gain});
        write_reg(REG_COUNT, {24'd0, count});
        write_reg(REG_SCALE, scale);
    endtask

    task automatic random_command();
        logic [1:0] k;
        case ($urandom_range(0, 9))
            0, 1, 2, 3: k = KIND_MEASURE;
            4, 5, 6:    k = KIND_TARE;
            7:          k = KIND_SPARE;
            default:    k = KIND_TICK;
        endcase
        send_tick(k, 1'($urandom_range(0, 1)));
        while (rd_phase != RD_IDLE)
        begin
            if ($urandom_range(0, 9) == 0)
                send_tick(2'($urandom_range(0, 3)), 1'($urandom_range(0, 1)));
            else
                feed_conversion(pick_code(), int'($urandom_range(0, 3)),
                                1'($urandom_range(0, 1)));
        end
    endtask

    task automatic test_idle_and_defaults();
        send_tick(KIND_TICK, 1'b0);
        send_tick(KIND_TICK, 1'b1);
        send_tick(KIND_SPARE, 1'b0);
        send_tick(KIND_SPARE, 1'b1);
        command_with(KIND_MEASURE, 24'h7F_FFFF);
        command_with(KIND_MEASURE, 24'h80_0000);
    endtask

    task automatic test_gain_pulses();
        set_config(GAIN_128, 8'd1, SCALE_RESET);
        command_with(KIND_MEASURE, 24'h12_3456);
        set_config(GAIN_64, 8'd1, SCALE_RESET);
        command_with(KIND_MEASURE, 24'hAB_CDEF);
        set_config(GAIN_32, 8'd1, SCALE_RESET);
        command_with(KIND_MEASURE, 24'h55_AAAA);
        set_config(GAIN_SPARE, 8'd1, SCALE_RESET);
        command_with(KIND_MEASURE, 24'hFF_FFFF);
    endtask

    task automatic test_tare_offset();
        set_config(GAIN_128, 8'd1, SCALE_RESET);
        command_with(KIND_TARE, 24'h80_0000);
        command_with(KIND_MEASURE, 24'h7F_FFFF);
        command_with(KIND_MEASURE, 24'h80_0000);
        command_with(KIND_TARE, 24'h00_0000);
    endtask

    task automatic test_scale_extremes();
        logic [31:0] scales[5];
        scales = '{SCALE_ZERO, 32'd1, 32'hFFFF_FFFF, 32'h8000_0000, 32'h7FFF_FFFF};
        foreach (scales[i])
        begin
            set_config(GAIN_128, 8'd1, scales[i]);
            command_with(KIND_MEASURE, 24'h7F_FFFF);
            command_with(KIND_MEASURE, 24'h80_0000);
        end
        // tare under zero scale must not flag an error
        set_config(GAIN_128, 8'd1, SCALE_ZERO);
        command_with(KIND_TARE, 24'h00_0000);
    endtask

    task automatic test_sample_counts();
        set_config(GAIN_64, 8'd2, SCALE_RESET);
        send_tick(KIND_MEASURE, 1'b1);
        feed_conversion(24'd1, 2, 1'b0);
        feed_conversion(24'd2, 0, 1'b0);
        send_tick(KIND_MEASURE, 1'b0);
        feed_conversion(24'hFF_FFFF, 1, 1'b0);
        feed_conversion(24'hFF_FFFE, 3, 1'b0);
        set_config(GAIN_32, 8'd0, SCALE_RESET);
        command_with(KIND_MEASURE, 24'd5);
        set_config(GAIN_128, 8'd3, SCALE_RESET);
        tx_idle_on = 1'b0;
        rx_idle_on = 1'b0;
        command_with(KIND_TARE, 24'h7F_FFFF);
        tx_idle_on = 1'b1;
        rx_idle_on = 1'b1;
    endtask

    task automatic test_busy_commands();
        set_config(GAIN_128, 8'd2, 32'h0000_4000);
        send_tick(KIND_MEASURE, 1'b1);
        while (rd_phase != RD_IDLE)
            feed_conversion(pick_code(), int'($urandom_range(0, 5)), 1'b1);
        send_tick(KIND_TARE, 1'b0);
        while (rd_phase != RD_IDLE)
            feed_conversion(pick_code(), int'($urandom_range(0, 5)), 1'b1);
    endtask

    task automatic test_back_pressure();
        set_config(GAIN_64, 8'd1, pick_scale());
        tx_idle_on = 1'b0;
        holds_requested++;
        repeat (3) random_command();
        tx_quiet();
        wait_drained();
        tx_idle_on = 1'b1;
        repeat (2) random_command();
    endtask

    task automatic test_random_traffic();
        int first_tick;
        int first_avg;
        first_tick = ticks_sent;
        first_avg = averages_done;
        while (ticks_sent - first_tick < RANDOM_TICKS
               || averages_done - first_avg < RANDOM_AVERAGES)
        begin
            set_config(2'($urandom_range(0, 3)), pick_count(), pick_scale());
            tx_idle_on = ($urandom_range(0, 4) != 0);
            rx_idle_on = ($urandom_range(0, 4) != 0);
            repeat ($urandom_range(2, 5)) random_command();
        end
        tx_idle_on = 1'b1;
        rx_idle_on = 1'b1;
    endtask

    always @(posedge clk)
    begin : result_check
        reading_t want;
        int       stall_left;
        int       hold_left;
        if (out_valid && !out_stall)
        begin
            if (readings_due.size() == 0)
            begin
                mismatches++;
                if (mismatches <= 10)
                    $display("%0t: result with no request outstanding", $realtime);
            end
            else
            begin
                want = readings_due.pop_front();
                if ({sck_level, busy_res, result_valid, result_is_tare, raw_average,
                     units_q16, scale_error} !== want)
                begin
                    mismatches++;
                    if (mismatches <= 10)
                    begin
                        $display("%0t: exp sck %0b busy %0b vld %0b tare %0b avg %0d units %0d err %0b",
                                 $realtime, want.sck, want.busy, want.valid, want.is_tare,
                                 $signed(want.avg), $signed(want.units), want.serr);
                        $display("%0t: got sck %0b busy %0b vld %0b tare %0b avg %0d units %0d err %0b",
                                 $realtime, sck_level, busy_res, result_valid, result_is_tare,
                                 raw_average, units_q16, scale_error);
                    end
                end
            end
            stall_left = rx_idle_on ? int'($urandom_range(0, 8)) : 0;
        end
        else if (stall_left != 0)
            stall_left--;
        if (holds_served != holds_requested)
        begin
            holds_served++;
            hold_left = HOLD_CYCLES;
        end
        else if (hold_left != 0)
            hold_left--;
        out_stall <= (stall_left != 0) || (hold_left != 0);
    end

    initial
    begin : watchdog
        int quiet;
        quiet = 0;
        while (quiet < STALL_LIMIT)
        begin
            @(posedge clk);
            if ((in_valid && !in_stall) || (out_valid && !out_stall) || (cfg_valid && cfg_ready))
                quiet = 0;
            else
                quiet++;
        end
        $display("watchdog: no handshake for %0d cycles", STALL_LIMIT);
        $display("** load_cell_adc_serial_reader_unit: FAILED **");
        $finish;
    end

    initial
    begin
        repeat (5) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);
        test_idle_and_defaults();
        test_gain_pulses();
        test_tare_offset();
        test_scale_extremes();
        test_sample_counts();
        test_busy_commands();
        test_back_pressure();
        test_random_traffic();
        tx_quiet();
        wait_drained();
        repeat (20) @(posedge clk);
        if (readings_due.size() != 0)
            $display("%0d requests left without a result", readings_due.size());
        if (mismatches == 0 && readings_due.size() == 0)
            $display("** load_cell_adc_serial_reader_unit: PASSED **");
        else
            $display("** load_cell_adc_serial_reader_unit: FAILED **");
        $finish;
    end

endmodule

// File: load_cell_adc_serial_reader_unit.f
design/lcadc_pkg.sv
design/lcadc_div.sv
design/load_cell_adc_serial_reader_unit.sv
verif/load_cell_adc_serial_reader_unit_test.sv
